@@ hw/rtl/edf_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// edf_pkg
// Shared types and constants of the deadline-sorted task table.
// ----------------------------------------------------------------------------
package edf_pkg;

	localparam int DEPTH_DEF      = 16;
	localparam int TIME_WIDTH_DEF = 32;
	localparam int CAP_W          = 5;
	localparam int ID_W           = 8;
	localparam int POS_W          = 5;
	localparam int STAT_W         = 3;
	localparam int CAP_RESET      = 16;

	typedef enum logic [1:0] {
		CMD_INSERT = 2'd0,
		CMD_REMOVE = 2'd1,
		CMD_EXPIRE = 2'd2,
		CMD_NONE   = 2'd3
	} cmd_t;

	typedef enum logic [STAT_W-1:0] {
		ST_INSERTED  = 3'd0,
		ST_FULL      = 3'd1,
		ST_REMOVED   = 3'd2,
		ST_NOT_FOUND = 3'd3,
		ST_EXPIRED   = 3'd4,
		ST_NONE_EXP  = 3'd5
	} status_t;

	typedef struct packed {
		logic [ID_W-1:0]   result_id;
		logic [POS_W-1:0]  position;
		logic [POS_W-1:0]  occupancy;
		status_t           status;
		logic              last;
	} result_t;

endpackage
`default_nettype wire

@@ hw/rtl/edf_front.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// edf_front
// Accepts command transactions, drops unknown codes, queues the rest.
// ----------------------------------------------------------------------------
module edf_front #(
	parameter int TW = edf_pkg::TIME_WIDTH_DEF
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  in_valid,
	output logic                       in_ready,
	input  wire edf_pkg::cmd_t         in_cmd,
	input  wire logic [7:0]            in_id,
	input  wire logic [TW-1:0]         in_dl,
	input  wire logic [TW-1:0]         in_rel,
	input  wire logic                  in_ap,
	input  wire logic [TW-1:0]         in_now,
	output logic                       q_valid,
	input  wire logic                  q_pop,
	output edf_pkg::cmd_t              q_cmd,
	output logic [7:0]                 q_id,
	output logic [TW-1:0]              q_dl,
	output logic [TW-1:0]              q_rel,
	output logic                       q_ap,
	output logic [TW-1:0]              q_now
);
	import edf_pkg::*;

	// two-entry queue
	cmd_t            cmd_q [2];
	logic [7:0]      id_q  [2];
	logic [TW-1:0]   dl_q  [2];
	logic [TW-1:0]   rel_q [2];
	logic            ap_q  [2];
	logic [TW-1:0]   now_q [2];
	logic            wp_q, rp_q;
	logic [1:0]      cnt_q;
	logic            push;

	assign in_ready = (cnt_q != 2'd2);
	assign push     = in_valid && in_ready && (in_cmd != CMD_NONE);
	assign q_valid  = (cnt_q != 2'd0);
	assign q_cmd    = cmd_q[rp_q];
	assign q_id     = id_q[rp_q];
	assign q_dl     = dl_q[rp_q];
	assign q_rel    = rel_q[rp_q];
	assign q_ap     = ap_q[rp_q];
	assign q_now    = now_q[rp_q];

	// queue storage
	always_ff @(posedge clk) begin
		if (push) begin
			cmd_q[wp_q] <= in_cmd;
			id_q[wp_q]  <= in_id;
			dl_q[wp_q]  <= in_dl;
			rel_q[wp_q] <= in_rel;
			ap_q[wp_q]  <= in_ap;
			now_q[wp_q] <= in_now;
		end
	end

	// queue pointers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) wp_q <= ~wp_q;
			if (q_pop) rp_q <= ~rp_q;
			cnt_q <= cnt_q + 2'(push) - 2'(q_pop);
		end
	end
endmodule
`default_nettype wire

@@ hw/rtl/edf_back.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// edf_back
// Walks the task table one entry a cycle unless output stalls; emits results.
// ----------------------------------------------------------------------------
module edf_back #(
	parameter int DEPTH = edf_pkg::DEPTH_DEF,
	parameter int TW    = edf_pkg::TIME_WIDTH_DEF
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic [4:0]            cap,
	input  wire logic                  q_valid,
	output logic                       q_pop,
	input  wire edf_pkg::cmd_t         q_cmd,
	input  wire logic [7:0]            q_id,
	input  wire logic [TW-1:0]         q_dl,
	input  wire logic [TW-1:0]         q_rel,
	input  wire logic                  q_ap,
	input  wire logic [TW-1:0]         q_now,
	output logic                       res_valid,
	input  wire logic                  res_ready,
	output edf_pkg::result_t           res
);
	import edf_pkg::*;

	localparam int IW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);

	typedef enum logic [4:0] {
		S_IDLE = 5'b00001,
		S_SCAN = 5'b00010,
		S_WALK = 5'b00100,
		S_EMIT = 5'b01000,
		S_DONE = 5'b10000
	} state_t;

	state_t          state_q;
	logic [7:0]      ids_q [DEPTH];
	logic [TW-1:0]   dls_q [DEPTH];
	logic [TW-1:0]   rels_q[DEPTH];
	logic            aps_q [DEPTH];
	logic [CW-1:0]   count_q;
	logic [CW-1:0]   i_q;      // read index
	logic [CW-1:0]   rank_q;   // original rank for expire
	logic [CW-1:0]   left_q;   // overdue entries still to remove
	logic            found_q;
	logic            out_v_q;
	result_t         out_q;
	result_t         out_nxt;
	logic [CW-1:0]   capc;
	logic            hit;
	logic            out_free;
	logic            in_range;
	logic            ins_ok;
	logic            exp_take;
	logic            emit_go;
	logic            tbl_ins;
	logic            tbl_del;
	logic            out_load;
	logic [IW-1:0]   ix;

	assign capc     = (int'(cap) > DEPTH) ? CW'(DEPTH) : CW'(cap);
	assign ix       = i_q[IW-1:0];
	assign out_free = !out_v_q || res_ready;
	assign in_range = (i_q != count_q);
	assign ins_ok   = (count_q < capc);
	assign res_valid = out_v_q;
	assign res = out_q;

	// compare of the current entry for the current command
	always_comb begin
		hit = 1'b0;
		case (q_cmd)
			CMD_INSERT: hit = !q_ap && (q_dl < dls_q[ix] || aps_q[ix] ||
				(q_rel == rels_q[ix] && q_dl == dls_q[ix] && q_id < ids_q[ix]));
			CMD_REMOVE: hit = (ids_q[ix] == q_id);
			CMD_EXPIRE: hit = (dls_q[ix] < q_now);
			default:    hit = 1'b0;
		endcase
	end

	// table and output strobes
	assign exp_take = (state_q == S_WALK) && (q_cmd == CMD_EXPIRE) && in_range &&
		hit && out_free;
	assign emit_go  = (state_q == S_EMIT) && out_free;
	assign tbl_ins  = emit_go && (q_cmd == CMD_INSERT) && ins_ok;
	assign tbl_del  = exp_take || (emit_go && (q_cmd == CMD_REMOVE) && found_q);
	assign out_load = exp_take || emit_go;
	assign q_pop    = (state_q == S_DONE);

	// table storage, shifted on insert and removal
	always_ff @(posedge clk) begin
		if (tbl_del) begin
			for (int k = 0; k < DEPTH - 1; k++) begin
				if (k >= int'(i_q)) begin
					ids_q[k]  <= ids_q[k+1];
					dls_q[k]  <= dls_q[k+1];
					rels_q[k] <= rels_q[k+1];
					aps_q[k]  <= aps_q[k+1];
				end
			end
		end
		if (tbl_ins) begin
			for (int k = 1; k < DEPTH; k++) begin
				if (k > int'(i_q) && k <= int'(count_q)) begin
					ids_q[k]  <= ids_q[k-1];
					dls_q[k]  <= dls_q[k-1];
					rels_q[k] <= rels_q[k-1];
					aps_q[k]  <= aps_q[k-1];
				end
			end
			ids_q[ix]  <= q_id;
			dls_q[ix]  <= q_dl;
			rels_q[ix] <= q_rel;
			aps_q[ix]  <= q_ap;
		end
	end

	// next result transaction
	always_comb begin
		out_nxt.result_id = q_id;
		out_nxt.position  = '0;
		out_nxt.occupancy = POS_W'(count_q);
		out_nxt.status    = ST_NONE_EXP;
		out_nxt.last      = 1'b1;
		if (state_q == S_WALK) begin
			// expired entry: occupancy is the count once every overdue entry is gone
			out_nxt.result_id = ids_q[ix];
			out_nxt.position  = POS_W'(rank_q);
			out_nxt.occupancy = POS_W'(count_q - left_q);
			out_nxt.status    = ST_EXPIRED;
			out_nxt.last      = (left_q == CW'(1));
		end else begin
			case (q_cmd)
				CMD_INSERT: begin
					if (ins_ok) begin
						out_nxt.position  = POS_W'(i_q);
						out_nxt.occupancy = POS_W'(count_q + 1'b1);
						out_nxt.status    = ST_INSERTED;
					end else begin
						out_nxt.status    = ST_FULL;
					end
				end
				CMD_REMOVE: begin
					if (found_q) begin
						out_nxt.position  = POS_W'(i_q);
						out_nxt.occupancy = POS_W'(count_q - 1'b1);
						out_nxt.status    = ST_REMOVED;
					end else begin
						out_nxt.status    = ST_NOT_FOUND;
					end
				end
				default: out_nxt.result_id = '0;
			endcase
		end
	end

	// output register
	always_ff @(posedge clk) begin
		if (out_load) out_q <= out_nxt;
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			count_q <= '0;
			i_q     <= '0;
			rank_q  <= '0;
			left_q  <= '0;
			found_q <= 1'b0;
			out_v_q <= 1'b0;
		end else begin
			if (out_load) out_v_q <= 1'b1;
			else if (res_ready) out_v_q <= 1'b0;
			case (state_q)
				S_IDLE: if (q_valid) begin
					i_q     <= '0;
					rank_q  <= '0;
					left_q  <= '0;
					found_q <= 1'b0;
					if (q_cmd == CMD_EXPIRE)
						state_q <= (q_now != '0) ? S_SCAN : S_EMIT;
					else
						state_q <= S_WALK;
				end
				// count the overdue entries first
				S_SCAN: begin
					if (!in_range) begin
						i_q     <= '0;
						rank_q  <= '0;
						state_q <= (left_q == '0) ? S_EMIT : S_WALK;
					end else begin
						if (hit) left_q <= left_q + 1'b1;
						i_q <= i_q + 1'b1;
					end
				end
				S_WALK: begin
					if (q_cmd == CMD_INSERT && !ins_ok) begin
						state_q <= S_EMIT;
					end else if (!in_range) begin
						state_q <= S_EMIT;
					end else if (q_cmd == CMD_EXPIRE) begin
						if (!hit) begin
							i_q    <= i_q + 1'b1;
							rank_q <= rank_q + 1'b1;
						end else if (exp_take) begin
							// entry removed in place, the next one moves up
							count_q <= count_q - 1'b1;
							rank_q  <= rank_q + 1'b1;
							left_q  <= left_q - 1'b1;
							if (left_q == CW'(1)) state_q <= S_DONE;
						end
					end else if (hit) begin
						found_q <= 1'b1;
						state_q <= S_EMIT;
					end else begin
						i_q <= i_q + 1'b1;
					end
				end
				S_EMIT: if (out_free) begin
					state_q <= S_DONE;
					if (tbl_ins) count_q <= count_q + 1'b1;
					else if (tbl_del) count_q <= count_q - 1'b1;
				end
				S_DONE: state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule
`default_nettype wire

@@ hw/rtl/edf_sorted_task_table.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// edf_sorted_task_table
// Deadline-sorted task table with insert, remove and expire commands.
// ----------------------------------------------------------------------------
// Commands arrive on s_axis (tdata = command, task_id, deadline, release_time,
// aperiodic, now_tick). Results leave on m_axis with tlast on the final
// result of a command. The user must make cfg writes of max_tasks only
// while the block is idle; the block itself does not enforce this.
// A front queue of two commands takes input while the back walks the table,
// one entry a cycle. Insert and remove present their one result once that
// walk ends; the back finishes each command before it takes the next one
// from the queue. Expire first counts overdue entries in a pass, then walks
// again and emits one result per removed entry as it finds it, or a single
// none-expired result when nothing is overdue or now_tick is zero.
// Reset empties the table and sets the capacity to 16. A stalled m_axis
// holds the walk; the front queue keeps accepting until it holds two.
// Unknown command codes are dropped without a result.
// ----------------------------------------------------------------------------
module edf_sorted_task_table #(
	parameter int DEPTH      = edf_pkg::DEPTH_DEF,
	parameter int TIME_WIDTH = edf_pkg::TIME_WIDTH_DEF
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        s_axis_tvalid,
	output logic                             s_axis_tready,
	// command, task_id, deadline, release_time, aperiodic, now_tick
	input  wire logic [((3*TIME_WIDTH+11+7)/8)*8-1:0] s_axis_tdata,
	output logic                             m_axis_tvalid,
	input  wire logic                        m_axis_tready,
	// result_id, position, occupancy, status
	output logic [23:0]                      m_axis_tdata,
	output logic                             m_axis_tlast,
	input  wire logic                        cfg_valid,
	output logic                             cfg_ready,
	input  wire logic [4:0]                  cfg_data
);
	import edf_pkg::*;

	localparam int TW = TIME_WIDTH;

	logic [4:0] cap_q;
	logic q_valid, q_pop, q_ap;
	cmd_t q_cmd;
	logic [7:0] q_id;
	logic [TW-1:0] q_dl, q_rel, q_now;
	result_t res;

	assign cfg_ready = 1'b1;

	// capacity register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) cap_q <= 5'(CAP_RESET);
		else if (cfg_valid) cap_q <= cfg_data;
	end

	edf_front #(.TW(TW)) u_front (
		.clk, .arst_n,
		.in_valid(s_axis_tvalid), .in_ready(s_axis_tready),
		.in_cmd(cmd_t'(s_axis_tdata[1:0])), .in_id(s_axis_tdata[9:2]),
		.in_dl(s_axis_tdata[10 +: TW]), .in_rel(s_axis_tdata[10+TW +: TW]),
		.in_ap(s_axis_tdata[10+2*TW]), .in_now(s_axis_tdata[11+2*TW +: TW]),
		.q_valid, .q_pop, .q_cmd, .q_id, .q_dl, .q_rel, .q_ap, .q_now
	);

	edf_back #(.DEPTH(DEPTH), .TW(TW)) u_back (
		.clk, .arst_n, .cap(cap_q),
		.q_valid, .q_pop, .q_cmd, .q_id, .q_dl, .q_rel, .q_ap, .q_now,
		.res_valid(m_axis_tvalid), .res_ready(m_axis_tready), .res
	);

	assign m_axis_tdata = {3'b000, res.status, res.occupancy, res.position, res.result_id};
	assign m_axis_tlast = res.last;
endmodule
`default_nettype wire

@@ hw/rtl/edf_checker.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// edf_checker
// Port-level checks of the task table, bound to the top level.
// ----------------------------------------------------------------------------
module edf_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        m_axis_tvalid,
	input wire logic        m_axis_tready,
	input wire logic [23:0] m_axis_tdata,
	input wire logic        m_axis_tlast
);
	// stalled result holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("result changed under stall");
	// occupancy never above sixteen
	a_occ: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> m_axis_tdata[17:13] <= 5'd16)
		else $error("occupancy out of range");
	// only expired results may be non-final
	a_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tlast |-> m_axis_tdata[20:18] == 3'd4)
		else $error("non-final result not an expiry");
endmodule

bind edf_sorted_task_table edf_checker u_chk (
	.clk, .arst_n, .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tlast
);
`default_nettype wire

@@ bench/edf_sorted_task_table_tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// edf_sorted_task_table_tb
// Self-checking bench for the deadline-sorted task table. A scoreboard keeps
// its own copy of the table and capacity and predicts every result of each
// accepted command. The bench runs directed commands, then random traffic
// under several capacities, with random idling on both stream sides.
// ----------------------------------------------------------------------------
module edf_sorted_task_table_tb;
	import edf_pkg::*;

	localparam int DEPTH     = 16;
	localparam int CYC_LIMIT = 400000;
	localparam int SETTLE    = DEPTH + 12;

	// scoreboard with its own copy of the task table
	class edf_scoreboard;
		logic [7:0]  ids[DEPTH];
		logic [31:0] dls[DEPTH];
		logic [31:0] rels[DEPTH];
		bit          aps[DEPTH];
		int          count;
		int          cap;
		int          errors;
		result_t     pending[$];

		function new();
			count  = 0;
			cap    = CAP_RESET;
			errors = 0;
		endfunction

		function void push(logic [7:0] id, int pos, status_t st, bit fin);
			result_t r;
			r.result_id = id;
			r.position  = pos[4:0];
			r.occupancy = count[4:0];
			r.status    = st;
			r.last      = fin;
			pending.push_back(r);
		endfunction

		function void drop(int pos);
			for (int i = pos; i + 1 < count; i++) begin
				ids[i]  = ids[i+1];
				dls[i]  = dls[i+1];
				rels[i] = rels[i+1];
				aps[i]  = aps[i+1];
			end
			count--;
		endfunction

		// predict the results of one accepted command
		function void note_command(cmd_t c, logic [7:0] id, logic [31:0] dl,
				logic [31:0] rel, bit ap, logic [31:0] now_t);
			int eff;
			int pos;
			int rank;
			int i;
			logic [7:0] gone_id[$];
			int gone_rank[$];
			eff = (cap > DEPTH) ? DEPTH : cap;
			case (c)
				CMD_INSERT: begin
					if (count >= eff) begin
						push(id, 0, ST_FULL, 1);
					end else begin
						pos = count;
						if (!ap) begin
							for (i = 0; i < count; i++) begin
								if (dl < dls[i] || aps[i] ||
										(rel == rels[i] && dl == dls[i] && id < ids[i])) begin
									pos = i;
									break;
								end
							end
						end
						for (i = count; i > pos; i--) begin
							ids[i]  = ids[i-1];
							dls[i]  = dls[i-1];
							rels[i] = rels[i-1];
							aps[i]  = aps[i-1];
						end
						ids[pos]  = id;
						dls[pos]  = dl;
						rels[pos] = rel;
						aps[pos]  = ap;
						count++;
						push(id, pos, ST_INSERTED, 1);
					end
				end
				CMD_REMOVE: begin
					pos = -1;
					for (i = 0; i < count; i++) begin
						if (ids[i] == id) begin
							pos = i;
							break;
						end
					end
					if (pos < 0) begin
						push(id, 0, ST_NOT_FOUND, 1);
					end else begin
						drop(pos);
						push(id, pos, ST_REMOVED, 1);
					end
				end
				CMD_EXPIRE: begin
					// rank counts entries as they stood before the command
					if (now_t != 0) begin
						i = 0;
						rank = 0;
						while (i < count) begin
							if (dls[i] < now_t) begin
								gone_id.push_back(ids[i]);
								gone_rank.push_back(rank);
								drop(i);
							end else begin
								i++;
							end
							rank++;
						end
					end
					if (gone_id.size() == 0) begin
						push(8'd0, 0, ST_NONE_EXP, 1);
					end else begin
						foreach (gone_id[k])
							push(gone_id[k], gone_rank[k], ST_EXPIRED, k == gone_id.size() - 1);
					end
				end
				default: ;
			endcase
		endfunction

		task report(string msg);
			$display("mismatch at %0t: %s", $time, msg);
			errors++;
		endtask

		task check_result(result_t got);
			result_t want;
			if (pending.size() == 0) begin
				report($sformatf("unexpected result id=%0d", got.result_id));
			end else begin
				want = pending.pop_front();
				if (got.result_id !== want.result_id)
					report($sformatf("result_id %0d, expected %0d",
						got.result_id, want.result_id));
				if (got.position !== want.position)
					report($sformatf("position %0d, expected %0d",
						got.position, want.position));
				if (got.occupancy !== want.occupancy)
					report($sformatf("occupancy %0d, expected %0d",
						got.occupancy, want.occupancy));
				if (got.status !== want.status)
					report($sformatf("status %0d, expected %0d",
						got.status, want.status));
				if (got.last !== want.last)
					report($sformatf("tlast %0b, expected %0b", got.last, want.last));
			end
		endtask
	endclass

	logic         clk;
	logic         arst_n;
	logic         s_axis_tvalid;
	logic         s_axis_tready;
	logic [111:0] s_axis_tdata;
	logic         m_axis_tvalid;
	logic         m_axis_tready;
	logic [23:0]  m_axis_tdata;
	logic         m_axis_tlast;
	logic         cfg_valid;
	logic         cfg_ready;
	logic [4:0]   cfg_data;

	edf_scoreboard sb;
	bit            quiet;
	int            stall_left;
	int            cyc;

	edf_sorted_task_table u_top (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_data      (cfg_data)
	);

	always #6 clk = ~clk;

	// timeout
	always @(posedge clk) begin
		cyc <= cyc + 1;
		if (cyc > CYC_LIMIT) begin
			$display("edf_sorted_task_table test failed");
			$finish;
		end
	end

	// result side: random stall bursts, then check each transaction
	always @(posedge clk) begin
		result_t got;
		if (arst_n) begin
			if (m_axis_tvalid && m_axis_tready) begin
				got.result_id = m_axis_tdata[7:0];
				got.position  = m_axis_tdata[12:8];
				got.occupancy = m_axis_tdata[17:13];
				got.status    = status_t'(m_axis_tdata[20:18]);
				got.last      = m_axis_tlast;
				sb.check_result(got);
			end
			if (stall_left > 0) begin
				stall_left    <= stall_left - 1;
				m_axis_tready <= 1'b0;
			end else if (!quiet && $urandom_range(0, 5) == 0) begin
				stall_left    <= $urandom_range(0, 5);
				m_axis_tready <= 1'b0;
			end else begin
				m_axis_tready <= 1'b1;
			end
		end
	end

	// send one command transaction, with an optional idle burst first
	task send_cmd(cmd_t c, logic [7:0] id, logic [31:0] dl, logic [31:0] rel,
			bit ap, logic [31:0] now_t);
		if (!quiet && $urandom_range(0, 3) == 0) begin
			s_axis_tvalid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= {5'd0, now_t, ap, rel, dl, id, c};
		do @(posedge clk); while (!s_axis_tready);
		sb.note_command(c, id, dl, rel, ap, now_t);
	endtask

	// wait until the table has drained, then write the capacity
	task write_capacity(logic [4:0] value);
		s_axis_tvalid <= 1'b0;
		while (sb.pending.size() != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
		cfg_valid <= 1'b1;
		cfg_data  <= value;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		sb.cap = value;
	endtask

	// random command, mostly well-formed traffic on a small id and time range
	task random_cmd();
		int          pick;
		logic [7:0]  id;
		logic [31:0] dl;
		logic [31:0] rel;
		logic [31:0] now_t;
		pick  = $urandom_range(0, 99);
		id    = ($urandom_range(0, 7) == 0) ? 8'($urandom) : 8'($urandom_range(0, 15));
		dl    = ($urandom_range(0, 7) == 0) ? $urandom : 32'($urandom_range(100, 140));
		rel   = ($urandom_range(0, 7) == 0) ? $urandom : 32'($urandom_range(0, 2));
		now_t = ($urandom_range(0, 9) == 0) ? $urandom : 32'($urandom_range(95, 130));
		if (pick < 55) begin
			send_cmd(CMD_INSERT, id, dl, rel, $urandom_range(0, 5) == 0, $urandom);
		end else if (pick < 78) begin
			if (sb.count > 0 && $urandom_range(0, 3) != 0)
				id = sb.ids[$urandom_range(0, sb.count - 1)];
			send_cmd(CMD_REMOVE, id, $urandom, $urandom, $urandom_range(0, 1), $urandom);
		end else if (pick < 95) begin
			send_cmd(CMD_EXPIRE, id, $urandom, $urandom, $urandom_range(0, 1), now_t);
		end else begin
			send_cmd(CMD_NONE, id, dl, rel, $urandom_range(0, 1), now_t);
		end
	endtask

	initial begin
		sb            = new();
		clk           = 1'b0;
		arst_n        = 1'b0;
		cyc           = 0;
		quiet         = 1'b0;
		stall_left    = 0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata  = '0;
		m_axis_tready = 1'b0;
		cfg_valid     = 1'b0;
		cfg_data      = '0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: ordering rules, ties, duplicates, extremes
		send_cmd(CMD_INSERT, 8'd5, 32'd100, 32'd0, 0, 32'd0);
		send_cmd(CMD_INSERT, 8'd3, 32'd100, 32'd0, 0, 32'd0);
		send_cmd(CMD_INSERT, 8'd9, 32'd100, 32'd0, 0, 32'd0);
		send_cmd(CMD_INSERT, 8'd7, 32'd100, 32'd1, 0, 32'd0);
		send_cmd(CMD_INSERT, 8'd1, 32'd0, 32'd0, 1, 32'hFFFF_FFFF);
		send_cmd(CMD_INSERT, 8'd2, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 0, 32'd0);
		send_cmd(CMD_INSERT, 8'd255, 32'd0, 32'd0, 0, 32'd0);
		send_cmd(CMD_INSERT, 8'd0, 32'd50, 32'd7, 0, 32'd0);
		send_cmd(CMD_INSERT, 8'd3, 32'd200, 32'd0, 0, 32'd0);
		send_cmd(CMD_REMOVE, 8'd3, 32'd0, 32'd0, 0, 32'd0);
		send_cmd(CMD_REMOVE, 8'd3, 32'd0, 32'd0, 0, 32'd0);
		send_cmd(CMD_REMOVE, 8'd3, 32'd0, 32'd0, 0, 32'd0);
		send_cmd(CMD_REMOVE, 8'd200, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1, 32'hFFFF_FFFF);
		send_cmd(CMD_EXPIRE, 8'd0, 32'd0, 32'd0, 0, 32'd0);
		send_cmd(CMD_EXPIRE, 8'd0, 32'd0, 32'd0, 0, 32'd60);
		send_cmd(CMD_EXPIRE, 8'd0, 32'd0, 32'd0, 0, 32'd1);
		send_cmd(CMD_NONE, 8'd9, 32'd0, 32'd0, 0, 32'd0);
		send_cmd(CMD_EXPIRE, 8'd0, 32'd0, 32'd0, 0, 32'hFFFF_FFFF);
		send_cmd(CMD_REMOVE, 8'd2, 32'd0, 32'd0, 0, 32'd0);
		send_cmd(CMD_EXPIRE, 8'd0, 32'd0, 32'd0, 0, 32'd5);

		// capacity zero rejects everything
		write_capacity(5'd0);
		send_cmd(CMD_INSERT, 8'd4, 32'd10, 32'd0, 0, 32'd0);
		send_cmd(CMD_INSERT, 8'd6, 32'd10, 32'd0, 1, 32'd0);

		// capacity one
		write_capacity(5'd1);
		repeat (10) random_cmd();

		// capacity above the table depth is clamped
		write_capacity(5'd31);
		repeat (20) send_cmd(CMD_INSERT, 8'($urandom_range(0, 15)),
			32'($urandom_range(100, 140)), 32'($urandom_range(0, 2)), 0, 32'd0);
		repeat (30) random_cmd();

		write_capacity(5'd5);
		repeat (30) random_cmd();

		write_capacity(5'd16);
		repeat (30) random_cmd();
		quiet = 1'b1;
		repeat (20) random_cmd();

		s_axis_tvalid <= 1'b0;
		while (sb.pending.size() != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
		if (sb.errors == 0)
			$display("edf_sorted_task_table test passed");
		else
			$display("edf_sorted_task_table test failed");
		$finish;
	end

endmodule

@@ filelist.f @@
hw/rtl/edf_pkg.sv
hw/rtl/edf_front.sv
hw/rtl/edf_back.sv
hw/rtl/edf_sorted_task_table.sv
hw/rtl/edf_checker.sv
bench/edf_sorted_task_table_tb.sv
